### rtl/lru_replacement_tracker_unit_assert.svh
// Assertion macros shared by the replacement tracker RTL.
`ifndef LRU_REPLACEMENT_TRACKER_UNIT_ASSERT_SVH
`define LRU_REPLACEMENT_TRACKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LRU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define LRU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define LRU_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LRU_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/lru_pkg.sv
// Shared types and constants of the replacement tracker.
package lru_pkg;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRD,
		ST_SCMP,
		ST_DECIDE,
		ST_SHRD,
		ST_SHWR,
		ST_W0,
		ST_DONE
	} lru_state_t;
endpackage

### rtl/lru_if.sv
// Handshake channels carrying access items and result items.
interface lru_in_if #(parameter int KEY_WIDTH = 8);
	logic                 valid;
	logic                 ready;
	logic [KEY_WIDTH-1:0] access_key;
	modport source (output valid, output access_key, input ready);
	modport sink (input valid, input access_key, output ready);
endinterface

interface lru_out_if #(parameter int KEY_WIDTH = 8, parameter int CNT_W = 5);
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic                 evicted_valid;
	logic [KEY_WIDTH-1:0] evicted_key;
	logic [CNT_W-1:0]     occupancy;
	modport source (output valid, output hit, output evicted_valid, output evicted_key,
		output occupancy, input ready);
	modport sink (input valid, input hit, input evicted_valid, input evicted_key,
		input occupancy, output ready);
endinterface

### rtl/lru_replacement_tracker_unit.sv
// LRU replacement tracker: recency list held in a synchronous key memory.
// An item first searches the N held entries, then moves each of the S entries below the hit
// or insertion point up by one and writes the key at entry 0, in a read-modify-write walk.
// One item is in work at a time; the next is accepted in the cycle after the result is loaded,
// and a result that is not taken holds the walk in its last state.
// Reset clears the control state and the occupancy, sets capacity to 16; keys are not cleared.
`include "lru_replacement_tracker_unit_assert.svh"
module lru_replacement_tracker_unit
	import lru_pkg::*;
#(
	parameter int MAX_ENTRIES = 16,
	parameter int KEY_WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	lru_in_if.sink           req,
	lru_out_if.source        rsp
);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

	lru_state_t state_q, state_d;

	logic [CAP_W-1:0]     cap_q;
	logic [CNT_W-1:0]     held_q, idx_q, pos_q;
	logic [KEY_WIDTH-1:0] key_q, evk_q, rdata_q;
	logic                 found_q, evv_q;
	logic                 out_valid_q, out_hit_q, out_evv_q;
	logic [KEY_WIDTH-1:0] out_evk_q;
	logic [CNT_W-1:0]     out_occ_q;

	logic [KEY_WIDTH-1:0] mem [MAX_ENTRIES];
	logic                 mem_re, mem_we;
	logic [IDX_W-1:0]     mem_raddr, mem_waddr;
	logic [KEY_WIDTH-1:0] mem_wdata;

	logic [CNT_W-1:0] eff_cap;
	logic [CNT_W-1:0] top;
	logic             evict;
	logic             out_load;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (32'(cap_q) > MAX_ENTRIES) begin
			eff_cap = MAX_CNT;
		end else begin
			eff_cap = CNT_W'(cap_q);
		end
		evict = !found_q && (held_q >= eff_cap) && (held_q != '0);
		if (found_q) begin
			top = pos_q;
		end else if (evict) begin
			top = held_q - CNT_W'(1);
		end else begin
			top = held_q;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_raddr = IDX_W'(idx_q);
		mem_waddr = IDX_W'(idx_q);
		mem_wdata = rdata_q;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_SRD;
				end
			end
			ST_SRD: begin
				if (idx_q == held_q) begin
					state_d = ST_DECIDE;
				end else begin
					mem_re  = 1'b1;
					state_d = ST_SCMP;
				end
			end
			ST_SCMP: begin
				state_d = (rdata_q == key_q) ? ST_DECIDE : ST_SRD;
			end
			ST_DECIDE: begin
				if (found_q && pos_q == '0) begin
					state_d = ST_DONE;
				end else if (top != '0) begin
					state_d = ST_SHRD;
				end else begin
					state_d = ST_W0;
				end
			end
			ST_SHRD: begin
				mem_re    = 1'b1;
				mem_raddr = IDX_W'(idx_q - CNT_W'(1));
				state_d   = ST_SHWR;
			end
			ST_SHWR: begin
				mem_we  = 1'b1;
				state_d = (idx_q == CNT_W'(1)) ? ST_W0 : ST_SHRD;
			end
			ST_W0: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = key_q;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_RESET;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (state_q == ST_DECIDE && !found_q && !evict) begin
				held_q <= held_q + CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				key_q   <= req.access_key;
				idx_q   <= '0;
				found_q <= 1'b0;
				evv_q   <= 1'b0;
			end
			ST_SCMP: begin
				// The last entry searched on a miss is the eviction candidate.
				if (idx_q == held_q - CNT_W'(1)) begin
					evk_q <= rdata_q;
				end
				if (rdata_q == key_q) begin
					found_q <= 1'b1;
					pos_q   <= idx_q;
				end else begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			ST_DECIDE: begin
				evv_q <= evict;
				idx_q <= top;
			end
			ST_SHWR: begin
				idx_q <= idx_q - CNT_W'(1);
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_hit_q <= found_q;
			out_evv_q <= evv_q;
			out_evk_q <= evv_q ? evk_q : '0;
			out_occ_q <= held_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.hit           = out_hit_q;
	assign rsp.evicted_valid = out_evv_q;
	assign rsp.evicted_key   = out_evk_q;
	assign rsp.occupancy     = out_occ_q;

	`LRU_ASSERT_IMP(a_held_bound, clk, arst_n, 1'b1, held_q <= MAX_CNT)
	`LRU_ASSERT_NXT(a_accept_search, clk, arst_n, req.valid && req.ready, state_q == ST_SRD)
	`LRU_ASSERT_IMP(a_hit_no_evict, clk, arst_n, out_valid_q && out_hit_q, !out_evv_q)
	`LRU_ASSERT_IMP(a_evict_occ, clk, arst_n, out_valid_q && out_evv_q, out_occ_q != '0)
endmodule
